// ===== rtl/gammatone_four_pole_filter_bank_assert.svh =====
// assertion macros for the gammatone filter bank
`ifndef GAMMATONE_FOUR_POLE_FILTER_BANK_ASSERT_SVH
`define GAMMATONE_FOUR_POLE_FILTER_BANK_ASSERT_SVH

// same-cycle implication, checked on every clock out of reset
`define GTFB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GTFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gtfb_pkg.sv =====
// ----------------------------------------------------------------------------
// gtfb_pkg
// shared widths, types and codes of the gammatone filter bank
// ----------------------------------------------------------------------------
package gtfb_pkg;

  localparam int CHANNELS       = 64;
  localparam int COEF_FRAC_BITS = 28;
  localparam int CH_W           = $clog2(CHANNELS);
  localparam int ACT_W          = 7;
  localparam int CSEL_W         = 3;
  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 32;
  localparam int OUT_W          = 32;
  localparam int PROD_W         = 2 * COEF_W;
  localparam int ACC_W          = PROD_W + 4;
  localparam int HIST_TAPS      = 4;
  localparam int HIST_SEL_W     = 2;
  localparam int COEF_AW        = CH_W + CSEL_W;
  localparam int HIST_AW        = CH_W + HIST_SEL_W;
  localparam int STEP_W         = 5;

  // coefficient select code that names no coefficient
  localparam logic [CSEL_W-1:0] CSEL_NONE = 3'd7;

  // input item modes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  // sequencer step limits
  localparam logic [STEP_W-1:0] LOAD_LAST = 5'd7;
  localparam logic [STEP_W-1:0] MAC_LAST  = 5'd21;
  localparam logic [STEP_W-1:0] MAC_B_FIRST = 5'd16;
  localparam logic [STEP_W-1:0] WB_FIRST  = 5'd1;
  localparam logic [STEP_W-1:0] WB_LAST   = 5'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_DRAIN,
    ST_OUT,
    ST_WB
  } state_t;

  typedef struct packed {
    state_t             state;
    logic [CH_W-1:0]    chan;
    logic [STEP_W-1:0]  step;
    logic [HIST_AW-1:0] clr_addr;
  } ctrl_t;

endpackage

// ===== rtl/gtfb_in_if.sv =====
// ----------------------------------------------------------------------------
// gtfb_in_if
// input item channel: samples and coefficient writes
// ----------------------------------------------------------------------------
interface gtfb_in_if;
  import gtfb_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic signed [SAMPLE_W-1:0] sample;
  logic [CH_W-1:0]            channel;
  logic [CSEL_W-1:0]          coef_select;
  logic signed [COEF_W-1:0]   coef_real;
  logic signed [COEF_W-1:0]   coef_imag;

  modport source (output valid, mode, sample, channel, coef_select, coef_real, coef_imag,
                  input ready);
  modport sink (input valid, mode, sample, channel, coef_select, coef_real, coef_imag,
                output ready);
endinterface

// ===== rtl/gtfb_out_if.sv =====
// ----------------------------------------------------------------------------
// gtfb_out_if
// result channel: one complex output per channel
// ----------------------------------------------------------------------------
interface gtfb_out_if;
  import gtfb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CH_W-1:0]         out_channel;
  logic signed [OUT_W-1:0] out_real;
  logic signed [OUT_W-1:0] out_imag;
  logic                    last;

  modport source (output valid, out_channel, out_real, out_imag, last, input ready);
  modport sink (input valid, out_channel, out_real, out_imag, last, output ready);
endinterface

// ===== rtl/gtfb_cfg_if.sv =====
// ----------------------------------------------------------------------------
// gtfb_cfg_if
// configuration write channel for the active channel count
// ----------------------------------------------------------------------------
interface gtfb_cfg_if;
  import gtfb_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/gtfb_mac.sv =====
// ----------------------------------------------------------------------------
// gtfb_mac
// shared complex multiply-accumulate unit with rounding and saturation
// ----------------------------------------------------------------------------
module gtfb_mac (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            acc_clr,
  input  logic                            issue,
  input  logic                            dst_im,
  input  logic                            neg,
  input  logic signed [gtfb_pkg::COEF_W-1:0] op_a,
  input  logic signed [gtfb_pkg::COEF_W-1:0] op_b,
  output logic signed [gtfb_pkg::OUT_W-1:0]  y_re,
  output logic signed [gtfb_pkg::OUT_W-1:0]  y_im
);
  import gtfb_pkg::*;

  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(32'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SMIN = -(ACC_W'(1) <<< (OUT_W - 1));

  logic signed [PROD_W-1:0] prod_r;
  logic                     pv_r, pdst_r, pneg_r;
  logic signed [ACC_W-1:0]  acc_re_r, acc_im_r, acc_re_nxt, acc_im_nxt;
  logic signed [ACC_W-1:0]  term;

  function automatic logic signed [OUT_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    sh = (acc + RND) >>> COEF_FRAC_BITS;
    if (sh > SMAX) begin
      finish = SMAX[OUT_W-1:0];
    end else if (sh < SMIN) begin
      finish = SMIN[OUT_W-1:0];
    end else begin
      finish = sh[OUT_W-1:0];
    end
  endfunction

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= issue;
    end
    prod_r <= op_a * op_b;
    pdst_r <= dst_im;
    pneg_r <= neg;
  end

  // accumulate stage
  always_comb begin
    term       = ACC_W'(prod_r);
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    if (acc_clr) begin
      acc_re_nxt = '0;
      acc_im_nxt = '0;
    end else if (pv_r) begin
      if (pdst_r) begin
        acc_im_nxt = pneg_r ? acc_im_r - term : acc_im_r + term;
      end else begin
        acc_re_nxt = pneg_r ? acc_re_r - term : acc_re_r + term;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_re_r <= acc_re_nxt;
    acc_im_r <= acc_im_nxt;
  end

  // round half up and saturate
  assign y_re = finish(acc_re_r);
  assign y_im = finish(acc_im_r);
endmodule

// ===== rtl/gtfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// gtfb_ctrl
// sequencer: clearing pass, per-channel load, multiply steps, drain, output and write-back
// ----------------------------------------------------------------------------
module gtfb_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      smp_start,
  input  logic                      out_free,
  input  logic [gtfb_pkg::CH_W-1:0] nm1,
  output gtfb_pkg::ctrl_t           ctrl,
  output logic                      in_ready
);
  import gtfb_pkg::*;

  state_t             state_r, state_nxt;
  logic [CH_W-1:0]    chan_r, chan_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [HIST_AW-1:0] clr_r, clr_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    chan_nxt  = chan_r;
    step_nxt  = step_r;
    clr_nxt   = clr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {HIST_AW{1'b1}}) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (smp_start) begin
          state_nxt = ST_LOAD;
          chan_nxt  = '0;
          step_nxt  = '0;
        end
      end
      ST_LOAD: begin
        if (step_r == LOAD_LAST) begin
          state_nxt = ST_MAC;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_MAC: begin
        if (step_r == MAC_LAST) state_nxt = ST_DRAIN;
        else step_nxt = step_r + 1'b1;
      end
      ST_DRAIN: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_WB;
          step_nxt  = WB_FIRST;
        end
      end
      ST_WB: begin
        if (step_r == WB_LAST) begin
          step_nxt = '0;
          if (chan_r == nm1) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_LOAD;
            chan_nxt  = chan_r + 1'b1;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      chan_r  <= '0;
      step_r  <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      chan_r  <= chan_nxt;
      step_r  <= step_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // outputs
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    ctrl.state    = state_r;
    ctrl.chan     = chan_r;
    ctrl.step     = step_r;
    ctrl.clr_addr = clr_r;
  end
endmodule

// ===== rtl/gammatone_four_pole_filter_bank.sv =====
// ----------------------------------------------------------------------------
// gammatone_four_pole_filter_bank
// complex fourth-order gammatone IIR bank sharing one multiply-accumulate unit
// ----------------------------------------------------------------------------
// coefficient write: accepted while idle; the block stays idle, so ready stays high
// sample: each active channel in turn runs load, multiply, drain, out and
//   write-back through the one shared multiplier; no new item is taken until
//   the last channel's write-back is done, and results that stall hold it longer
// first result is registered out of the out state after channel 0's load, multiply and drain
// reset: clearing pass zeroes all 256 output history entries; no input taken then
// ----------------------------------------------------------------------------
module gammatone_four_pole_filter_bank (
  input  logic          clk,
  input  logic          rst_n,
  gtfb_in_if.sink       in_ch,
  gtfb_out_if.source    out_ch,
  gtfb_cfg_if.sink      cfg_ch
);
  import gtfb_pkg::*;

  `include "gammatone_four_pole_filter_bank_assert.svh"

  ctrl_t ctrl;
  logic  in_ready, in_acc, smp_start, out_free;

  logic [ACT_W-1:0]  active_r;
  logic [ACT_W-1:0]  n_cnt;
  logic [CH_W-1:0]   nm1;

  logic [PROD_W-1:0] coef_mem [CHANNELS * 8];
  logic [PROD_W-1:0] hist_mem [CHANNELS * HIST_TAPS];
  logic [PROD_W-1:0] coef_rd_r, hist_rd_r;

  logic [COEF_AW-1:0] coef_raddr;
  logic [HIST_AW-1:0] hist_raddr, hist_waddr;
  logic [PROD_W-1:0]  hist_wdata;
  logic               hist_we;

  logic signed [COEF_W-1:0]   cr_r [7];
  logic signed [COEF_W-1:0]   ci_r [7];
  logic signed [OUT_W-1:0]    hr_r [HIST_TAPS];
  logic signed [OUT_W-1:0]    hi_r [HIST_TAPS];
  logic signed [SAMPLE_W-1:0] x_r  [3];
  logic signed [SAMPLE_W-1:0] sample_r;

  logic [STEP_W-1:0]  ld_idx;
  logic [CSEL_W-1:0]  cidx;
  logic [1:0]         hidx, xidx;
  logic [STEP_W-1:0]  bstep;
  logic               mac_issue, dst_im, neg, use_ci, use_hi;
  logic signed [COEF_W-1:0] op_a, op_b;
  logic signed [OUT_W-1:0]  y_re, y_im;

  logic                    out_valid_r;
  logic [CH_W-1:0]         out_chan_r;
  logic signed [OUT_W-1:0] out_re_r, out_im_r;
  logic                    out_last_r;
  logic                    end_item;

  // handshakes
  assign in_ch.ready  = in_ready;
  assign in_acc       = in_ch.valid & in_ready;
  assign smp_start    = in_acc & (in_ch.mode == MODE_SAMPLE);
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  // active count, clamped to one..CHANNELS
  always_comb begin
    n_cnt = active_r;
    if (active_r == '0) n_cnt = ACT_W'(1);
    else if (active_r > ACT_W'(CHANNELS)) n_cnt = ACT_W'(CHANNELS);
    nm1 = CH_W'(n_cnt - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACT_W'(64);
    end else if (cfg_ch.valid) begin
      active_r <= cfg_ch.data;
    end
  end

  gtfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .smp_start(smp_start),
    .out_free (out_free),
    .nm1      (nm1),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  // coefficient store
  assign coef_raddr = {ctrl.chan, ctrl.step[CSEL_W-1:0]};

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.mode == MODE_COEF && in_ch.coef_select != CSEL_NONE) begin
      coef_mem[{in_ch.channel, in_ch.coef_select}] <= {in_ch.coef_real, in_ch.coef_imag};
    end
    coef_rd_r <= coef_mem[coef_raddr];
  end

  // output history store: clearing pass, new output, then shifted taps
  assign hist_raddr = {ctrl.chan, ctrl.step[1:0]};

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = {ctrl.chan, ctrl.step[1:0]};
    hist_wdata = {hr_r[hidx], hi_r[hidx]};
    case (ctrl.state)
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = ctrl.clr_addr;
        hist_wdata = '0;
      end
      ST_OUT: begin
        hist_we    = out_free;
        hist_waddr = {ctrl.chan, 2'd0};
        hist_wdata = {y_re, y_im};
      end
      ST_WB: hist_we = 1'b1;
      default: hist_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_rd_r <= hist_mem[hist_raddr];
  end

  // capture this channel's coefficients and history from the registered read data, indexed by step minus one
  assign ld_idx = ctrl.step - 1'b1;

  always_ff @(posedge clk) begin
    if (ctrl.state == ST_LOAD && ctrl.step != '0) begin
      cr_r[ld_idx[CSEL_W-1:0]] <= coef_rd_r[PROD_W-1:COEF_W];
      ci_r[ld_idx[CSEL_W-1:0]] <= coef_rd_r[COEF_W-1:0];
      if (ctrl.step <= STEP_W'(HIST_TAPS)) begin
        hr_r[ld_idx[1:0]] <= hist_rd_r[PROD_W-1:OUT_W];
        hi_r[ld_idx[1:0]] <= hist_rd_r[OUT_W-1:0];
      end
    end
  end

  // input history: current sample enters after the item is done
  assign end_item = (ctrl.state == ST_WB) && (ctrl.step == WB_LAST) && (ctrl.chan == nm1);

  always_ff @(posedge clk) begin
    if (smp_start) sample_r <= in_ch.sample;
    if (!rst_n) begin
      x_r[0] <= '0;
      x_r[1] <= '0;
      x_r[2] <= '0;
    end else if (end_item) begin
      x_r[2] <= x_r[1];
      x_r[1] <= x_r[0];
      x_r[0] <= sample_r;
    end
  end

  // step decode: 16 feedback products, then 6 feed-forward products
  always_comb begin
    bstep     = ctrl.step - MAC_B_FIRST;
    xidx      = bstep[2:1];
    mac_issue = (ctrl.state == ST_MAC);
    if (ctrl.step < MAC_B_FIRST) begin
      cidx = {1'b0, ctrl.step[3:2]};
      case (ctrl.step[1:0])
        2'd0:    begin use_ci = 1'b0; use_hi = 1'b0; dst_im = 1'b0; neg = 1'b1; end
        2'd1:    begin use_ci = 1'b1; use_hi = 1'b1; dst_im = 1'b0; neg = 1'b0; end
        2'd2:    begin use_ci = 1'b0; use_hi = 1'b1; dst_im = 1'b1; neg = 1'b1; end
        default: begin use_ci = 1'b1; use_hi = 1'b0; dst_im = 1'b1; neg = 1'b1; end
      endcase
    end else begin
      cidx   = CSEL_W'(3'd4 + {1'b0, xidx});
      use_ci = bstep[0];
      use_hi = 1'b0;
      dst_im = bstep[0];
      neg    = 1'b0;
    end
  end

  // history index shared by the multiplier operand and the write-back
  assign hidx = (ctrl.state == ST_WB) ? ld_idx[1:0] : ctrl.step[3:2];

  always_comb begin
    op_a = use_ci ? ci_r[cidx] : cr_r[cidx];
    if (ctrl.step < MAC_B_FIRST) op_b = use_hi ? hi_r[hidx] : hr_r[hidx];
    else op_b = {x_r[xidx], {(COEF_W - SAMPLE_W){1'b0}}};
  end

  gtfb_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc_clr(ctrl.state == ST_LOAD),
    .issue  (mac_issue),
    .dst_im (dst_im),
    .neg    (neg),
    .op_a   (op_a),
    .op_b   (op_b),
    .y_re   (y_re),
    .y_im   (y_im)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.state == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (ctrl.state == ST_OUT && out_free) begin
      out_chan_r <= ctrl.chan;
      out_re_r   <= y_re;
      out_im_r   <= y_im;
      out_last_r <= (ctrl.chan == nm1);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_channel = out_chan_r;
  assign out_ch.out_real    = out_re_r;
  assign out_ch.out_imag    = out_im_r;
  assign out_ch.last        = out_last_r;

  // checks
  `GTFB_ASSERT_NOW(a_last_is_final, out_valid_r && out_last_r, out_chan_r == nm1, "last flag on wrong channel")
  `GTFB_ASSERT_NOW(a_no_input_in_clear, ctrl.state == ST_CLEAR, !in_ready, "input taken during clearing pass")
  `GTFB_ASSERT_NEXT(a_out_follows_load, ctrl.state == ST_OUT && out_free, out_valid_r, "result not presented after load")
endmodule

// ===== tb/gammatone_four_pole_filter_bank_tb.sv =====
// ----------------------------------------------------------------------------
// gammatone_four_pole_filter_bank_tb
// drives active count writes, coefficient writes and audio samples into the gammatone filter bank
// under random idling and stalls, predicts every channel's complex output with
// exact wide arithmetic, and checks each result transfer in order
// ----------------------------------------------------------------------------
module gammatone_four_pole_filter_bank_tb;
  import gtfb_pkg::*;

  localparam logic [CSEL_W-1:0] SEL_A1 = 3'd0;
  localparam logic [CSEL_W-1:0] SEL_B1 = 3'd4;
  localparam int NUM_COEF   = 7;
  localparam int SETTLE     = 48;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic                       mode;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CH_W-1:0]            channel;
    logic [CSEL_W-1:0]          csel;
    logic signed [COEF_W-1:0]   cre;
    logic signed [COEF_W-1:0]   cim;
  } bank_item_t;

  typedef struct {
    logic [CH_W-1:0]         chan;
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic                    last;
  } chan_out_t;

  // filter bank predictor and store of pending channel outputs
  class filter_bank_scoreboard;
    int        coef_re[CHANNELS][NUM_COEF];
    int        coef_im[CHANNELS][NUM_COEF];
    int        y_re[CHANNELS][HIST_TAPS];
    int        y_im[CHANNELS][HIST_TAPS];
    int        x_hist[3];
    int        n_active;
    int        mismatches;
    chan_out_t pending[$];

    function new();
      foreach (coef_re[c, k]) begin
        coef_re[c][k] = 0;
        coef_im[c][k] = 0;
      end
      foreach (y_re[c, k]) begin
        y_re[c][k] = 0;
        y_im[c][k] = 0;
      end
      foreach (x_hist[k]) x_hist[k] = 0;
      n_active = CHANNELS;
      mismatches = 0;
    endfunction

    function void set_active(logic [ACT_W-1:0] v);
      n_active = (v == 0) ? 1 : ((v > CHANNELS) ? CHANNELS : int'(v));
    endfunction

    // round half up, dropping 28 fraction bits, then saturate to 32 bits
    function int round_sat(logic signed [127:0] acc);
      logic signed [127:0] s;
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      hi_lim = (128'sd1 <<< 31) - 128'sd1;
      lo_lim = -(128'sd1 <<< 31);
      s = (acc + (128'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      if (s > hi_lim) return 32'h7FFFFFFF;
      if (s < lo_lim) return 32'h80000000;
      return int'(s);
    endfunction

    function void note_input(bank_item_t it);
      logic signed [127:0] acc_re;
      logic signed [127:0] acc_im;
      longint ar, ai, hr, hi, x;
      chan_out_t e;
      int yr, yi;
      if (it.mode == MODE_COEF) begin
        if (it.csel != CSEL_NONE) begin
          coef_re[it.channel][it.csel] = it.cre;
          coef_im[it.channel][it.csel] = it.cim;
        end
        return;
      end
      for (int c = 0; c < n_active; c++) begin
        acc_re = 0;
        acc_im = 0;
        for (int k = 0; k < HIST_TAPS; k++) begin
          ar = coef_re[c][k];
          ai = coef_im[c][k];
          hr = y_re[c][k];
          hi = y_im[c][k];
          acc_re = acc_re - ar * hr + ai * hi;
          acc_im = acc_im - ar * hi - ai * hr;
        end
        for (int k = 0; k < 3; k++) begin
          x = longint'(x_hist[k]) * 65536;
          acc_re = acc_re + longint'(coef_re[c][SEL_B1 + k]) * x;
          acc_im = acc_im + longint'(coef_im[c][SEL_B1 + k]) * x;
        end
        yr = round_sat(acc_re);
        yi = round_sat(acc_im);
        for (int k = HIST_TAPS - 1; k > 0; k--) begin
          y_re[c][k] = y_re[c][k-1];
          y_im[c][k] = y_im[c][k-1];
        end
        y_re[c][0] = yr;
        y_im[c][0] = yi;
        e.chan = CH_W'(c);
        e.re = yr;
        e.im = yi;
        e.last = (c + 1 == n_active);
        pending.insert(pending.size(), e);
      end
      x_hist[2] = x_hist[1];
      x_hist[1] = x_hist[0];
      x_hist[0] = it.sample;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(chan_out_t got);
      chan_out_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected output on channel %0d", got.chan));
        return;
      end
      e = pending.pop_front();
      if (got.chan !== e.chan)
        report_mismatch($sformatf("channel got %0d exp %0d", got.chan, e.chan));
      if (got.re !== e.re)
        report_mismatch($sformatf("ch %0d real got %h exp %h", e.chan, got.re, e.re));
      if (got.im !== e.im)
        report_mismatch($sformatf("ch %0d imag got %h exp %h", e.chan, got.im, e.im));
      if (got.last !== e.last)
        report_mismatch($sformatf("ch %0d last got %b exp %b", e.chan, got.last, e.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   no_idle = 1'b0;
  bit   coef_written[CHANNELS][NUM_COEF];
  filter_bank_scoreboard sb;

  gtfb_in_if  in_if();
  gtfb_out_if out_if();
  gtfb_cfg_if cfg_if();

  gammatone_four_pole_filter_bank dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source),
    .cfg_ch (cfg_if.sink)
  );

  // clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: random stalls, checks on each transfer
  initial begin
    chan_out_t got;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = no_idle || ($urandom_range(0, 99) >= 16);
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got.chan = out_if.out_channel;
        got.re   = out_if.out_real;
        got.im   = out_if.out_imag;
        got.last = out_if.last;
        sb.check_result(got);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(bank_item_t it);
    while (!no_idle && $urandom_range(0, 99) < 16) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid       = 1'b1;
    in_if.mode        = it.mode;
    in_if.sample      = it.sample;
    in_if.channel     = it.channel;
    in_if.coef_select = it.csel;
    in_if.coef_real   = it.cre;
    in_if.coef_imag   = it.cim;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(it);
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic send_coef(int ch, logic [CSEL_W-1:0] sel, int re, int im);
    bank_item_t it;
    it = '{mode: MODE_COEF, sample: SAMPLE_W'($urandom), channel: CH_W'(ch), csel: sel,
           cre: re, cim: im};
    if (sel != CSEL_NONE) coef_written[ch][sel] = 1'b1;
    send_item(it);
  endtask

  task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
    bank_item_t it;
    it = '{mode: MODE_SAMPLE, sample: s, channel: CH_W'($urandom), csel: CSEL_W'($urandom),
           cre: $urandom, cim: $urandom};
    send_item(it);
  endtask

  // mostly small coefficients keep the filters from saturating at once
  function automatic int rand_coef();
    int v;
    v = $urandom;
    if ($urandom_range(0, 3) != 0) v = v >>> $urandom_range(4, 9);
    return v;
  endfunction

  task automatic fill_channels(int n);
    for (int c = 0; c < n; c++)
      for (int k = 0; k < NUM_COEF; k++)
        if (!coef_written[c][k]) send_coef(c, CSEL_W'(k), rand_coef(), rand_coef());
  endtask

  // wait until every expected output has come and the block has settled
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_active(logic [ACT_W-1:0] v);
    drain();
    cfg_if.valid = 1'b1;
    cfg_if.data  = v;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_active(v);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // random mix of samples and coefficient writes
  task automatic random_items(int count, int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain();
      if ($urandom_range(0, 99) < 70)
        send_sample(SAMPLE_W'($urandom));
      else
        send_coef($urandom_range(0, CHANNELS - 1), CSEL_W'($urandom_range(0, NUM_COEF)),
                  rand_coef(), rand_coef());
    end
  endtask

  initial begin
    sb = new();
    in_if.valid = 1'b0;
    in_if.mode = MODE_SAMPLE;
    in_if.sample = '0;
    in_if.channel = '0;
    in_if.coef_select = '0;
    in_if.coef_real = '0;
    in_if.coef_imag = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed: one channel, extreme coefficients and samples, saturation
    write_active(7'd1);
    send_coef(0, SEL_A1, 32'sh7FFFFFFF, 32'sh80000000);
    send_coef(0, SEL_A1 + 3'd1, 0, 0);
    send_coef(0, SEL_A1 + 3'd2, 32'sh80000000, 32'sh7FFFFFFF);
    send_coef(0, SEL_A1 + 3'd3, -1, 1);
    send_coef(0, SEL_B1, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_coef(0, SEL_B1 + 3'd1, 32'sh80000000, 32'sh80000000);
    send_coef(0, SEL_B1 + 3'd2, 32'sh10000000, -32'sh10000000);
    send_coef(0, CSEL_NONE, 32'sh5A5A5A5A, 32'shA5A5A5A5);
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sh0001);
    send_sample(16'sh0001);
    send_coef(0, SEL_A1, 32'sh08000000, 0);
    send_coef(0, SEL_A1 + 3'd2, 0, 0);
    send_sample(16'sh1234);
    send_sample(-16'sh4321);

    // zero active count behaves as one
    write_active(7'd0);
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    send_sample(16'sh0101);

    // a handful of channels, random traffic
    write_active(7'd8);
    fill_channels(8);
    random_items(60, 30);

    // wider bank with no idling at all, then a smaller count
    fill_channels(16);
    write_active(7'd16);
    no_idle = 1'b1;
    repeat (5) send_sample(SAMPLE_W'($urandom));
    no_idle = 1'b0;
    write_active(7'd12);
    repeat (5) send_sample(SAMPLE_W'($urandom));

    // small bank, random traffic with a pause until drained
    write_active(7'd3);
    random_items(70, 35);

    drain();
    if (sb.mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
